// File: design/plid_pkg.sv
// shared types, codes and field widths of the positional list
package plid_pkg;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam int unsigned DEF_CAPACITY = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_POS   = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_BACK  = 3'd4,
    CMD_DEL_POS   = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // per-cell load controls for one cycle
  typedef struct packed {
    logic load_new;
    logic from_left;
    logic from_right;
    logic tap;
  } cell_ctl_t;

endpackage

// File: design/plid_cell.sv
// one list cell: holds one entry and shifts toward either neighbor
module plid_cell
  import plid_pkg::*;
(
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [DATA_W-1:0] new_data,
  input  logic [DATA_W-1:0] left_data,
  input  logic [DATA_W-1:0] right_data,
  output logic [DATA_W-1:0] data,
  output logic [DATA_W-1:0] tap_data
);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.load_new) begin
      data_nxt = new_data;
    end else if (ctl.from_left) begin
      data_nxt = left_data;
    end else if (ctl.from_right) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data     = data_r;
  assign tap_data = ctl.tap ? data_r : '0;

endmodule

// File: design/plid_ctrl.sv
// command decode, range checks and per-cell shift controls
module plid_ctrl
  import plid_pkg::*;
#(
  parameter int unsigned CAPACITY = DEF_CAPACITY,
  parameter int unsigned OCC_W    = $clog2(CAPACITY + 1)
) (
  input  logic [CMD_W-1:0] cmd,
  input  logic [POS_W-1:0] position,
  input  logic [OCC_W-1:0] occ,
  input  logic             go,
  output status_t          status,
  output logic [OCC_W-1:0] occ_nxt,
  output cell_ctl_t        cell_ctl [CAPACITY]
);

  localparam int unsigned CMP_W = ((OCC_W > POS_W) ? OCC_W : POS_W) + 1;

  logic [CMP_W-1:0] pos_c;
  logic [CMP_W-1:0] occ_c;
  logic [CMP_W-1:0] idx_c;
  logic             full;
  logic             empty;
  logic             ins_pos_ok;
  logic             del_pos_ok;
  logic             ins;
  logic             del;

  assign pos_c      = CMP_W'(position);
  assign occ_c      = CMP_W'(occ);
  assign full       = (occ_c == CMP_W'(CAPACITY));
  assign empty      = (occ == '0);
  assign ins_pos_ok = (pos_c != '0) && (pos_c <= occ_c + CMP_W'(1));
  assign del_pos_ok = (pos_c != '0) && (pos_c <= occ_c);

  always_comb begin
    status  = ST_OK;
    ins     = 1'b0;
    del     = 1'b0;
    idx_c   = '0;
    occ_nxt = occ;
    case (cmd)
      CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_POS: begin
        if (full) begin
          status = ST_FULL;
        end else if ((cmd == CMD_INS_POS) && !ins_pos_ok) begin
          status = ST_RANGE;
        end else begin
          ins     = 1'b1;
          occ_nxt = occ + OCC_W'(1);
        end
      end
      CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_POS: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if ((cmd == CMD_DEL_POS) && !del_pos_ok) begin
          status = ST_RANGE;
        end else begin
          del     = 1'b1;
          occ_nxt = occ - OCC_W'(1);
        end
      end
      default: ;
    endcase
    case (cmd)
      CMD_INS_BACK:                idx_c = occ_c;
      CMD_DEL_BACK:                idx_c = occ_c - CMP_W'(1);
      CMD_INS_POS, CMD_DEL_POS:    idx_c = pos_c - CMP_W'(1);
      default:                     idx_c = '0;
    endcase
  end

  // insert: cells above idx take their left neighbor, idx takes the new item
  // delete: cells from idx up take their right neighbor, idx is tapped first
  always_comb begin
    logic [CMP_W-1:0] kc;
    kc = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      kc = CMP_W'(k);
      cell_ctl[k].load_new   = go && ins && (kc == idx_c);
      cell_ctl[k].from_left  = go && ins && (kc > idx_c);
      cell_ctl[k].from_right = go && del && (kc >= idx_c);
      cell_ctl[k].tap        = del && (kc == idx_c);
    end
  end

endmodule

// File: design/positional_list_insert_delete.sv
// top level of the positional list: cell row, control and result register
//
// Ordered list of up to CAPACITY signed 32-bit values held in a row of cells.
// Input channel in_*: one command item per handshake, tdata carries cmd,
// value and 1-based position. Commands insert at the front, the back or a
// position, or delete from the front, the back or a position.
// Result channel out_*: one item per command with status, removed value
// and the count after the command.
// Each command is decoded and applied to every cell in the cycle it is
// accepted; the result is registered and shown the next cycle, and one
// command per cycle is sustained while the receiver takes results. The
// single result register sets that rate: in_tready is high while the
// register is empty or being drained in the same cycle.
// A failed command (full, empty, position out of range) leaves the list as
// it was. When out_tready is low a pending result holds and in_tready drops.
// Reset empties the list (count zero) and clears the result valid; cell
// contents are not cleared and are never read before being written.
module positional_list_insert_delete
  import plid_pkg::*;
#(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // cmd [2:0], value [34:3], position [39:35]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // status [1:0], removed_value [33:2], count [38:34], zero [39]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int unsigned OCC_W = $clog2(CAPACITY + 1);

  logic [CMD_W-1:0]  in_cmd;
  logic [DATA_W-1:0] in_value;
  logic [POS_W-1:0]  in_position;
  logic              accept;

  logic [OCC_W-1:0]  occ_r;
  logic [OCC_W-1:0]  occ_nxt;
  status_t           status;
  cell_ctl_t         cell_ctl [CAPACITY];
  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] tap_data [CAPACITY];
  logic [DATA_W-1:0] removed;

  logic              out_valid_r;
  status_t           status_r;
  logic [DATA_W-1:0] removed_r;
  logic [COUNT_W-1:0] count_r;

  assign in_cmd      = in_tdata[2:0];
  assign in_value    = in_tdata[34:3];
  assign in_position = in_tdata[39:35];

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  plid_ctrl #(
    .CAPACITY (CAPACITY),
    .OCC_W    (OCC_W)
  ) u_ctrl (
    .cmd      (in_cmd),
    .position (in_position),
    .occ      (occ_r),
    .go       (accept),
    .status   (status),
    .occ_nxt  (occ_nxt),
    .cell_ctl (cell_ctl)
  );

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [DATA_W-1:0] left_data;
    logic [DATA_W-1:0] right_data;
    if (k == 0) begin : g_first
      assign left_data = in_value;
    end else begin : g_inner_l
      assign left_data = cell_data[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right_data = cell_data[k];
    end else begin : g_inner_r
      assign right_data = cell_data[k+1];
    end
    plid_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[k]),
      .new_data   (in_value),
      .left_data  (left_data),
      .right_data (right_data),
      .data       (cell_data[k]),
      .tap_data   (tap_data[k])
    );
  end

  // at most one cell is tapped, the rest give zero
  always_comb begin
    removed = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      removed = removed | tap_data[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        occ_r       <= occ_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= status;
      removed_r <= removed;
      count_r   <= COUNT_W'(occ_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, count_r, removed_r, status_r};

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(CAPACITY))
    else $error("occupancy above capacity");

  a_ok_count: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (status == ST_OK) && (occ_nxt != occ_r) |=>
      (COUNT_W'(occ_r) == count_r))
    else $error("result count differs from list occupancy");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r == ST_EMPTY) |-> (count_r == '0))
    else $error("empty status with nonzero count");

  a_fail_hold: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (status != ST_OK) |=> (occ_r == $past(occ_r)) && (removed_r == '0))
    else $error("failed command changed the list");
`endif

endmodule
